@@ hw/rtl/qns_pkg.sv @@
`default_nettype none

package qns_pkg;

	// default clip length of one name part, in bytes
	localparam int NAME_LIMIT_DEF = 63;

	// width of the part length counter
	localparam int LEN_W = 7;

	// characters with a meaning of their own
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_PAREN = 8'h28;
	localparam logic [7:0] CH_DOLL  = 8'h24;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_NUL   = 8'h00;

	// status codes of a finished string
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_SIGNATURE = 3'd1;
	localparam logic [2:0] ST_UNCLOSED  = 3'd2;
	localparam logic [2:0] ST_EMPTY_Q   = 3'd3;
	localparam logic [2:0] ST_NO_BEFORE = 3'd4;
	localparam logic [2:0] ST_NO_AFTER  = 3'd5;
	localparam logic [2:0] ST_INVALID   = 3'd6;

	typedef enum logic [2:0] {
		M_START = 3'd0,
		M_PLAIN = 3'd1,
		M_QUOTE = 3'd2,
		M_QSEEN = 3'd3,
		M_AFTER = 3'd4,
		M_DRAIN = 3'd5
	} mode_t;

	// scanner state carried from byte to byte
	typedef struct packed {
		mode_t            mode;
		logic             seen_dot;
		logic [LEN_W-1:0] part_length;
		logic [7:0]       part_count;
		logic [2:0]       verdict;
	} scan_state_t;

	// one result word
	typedef struct packed {
		logic       has_char;
		logic [7:0] name_char;
		logic [7:0] part_number;
		logic       part_end;
		logic       finished;
		logic [2:0] status;
	} result_t;

	localparam scan_state_t STATE_RESET = '{
		mode:        M_START,
		seen_dot:    1'b0,
		part_length: '0,
		part_count:  8'd0,
		verdict:     ST_OK
	};

	function automatic logic is_blank(input logic [7:0] b);
		return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0D || b == 8'h0C;
	endfunction

	function automatic logic starts_name(input logic [7:0] b);
		return b == CH_UNDER || (b >= 8'h61 && b <= 8'h7A) ||
			(b >= 8'h41 && b <= 8'h5A) || b[7];
	endfunction

	function automatic logic continues_name(input logic [7:0] b);
		return (b >= 8'h30 && b <= 8'h39) || b == CH_DOLL || starts_name(b);
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5A) ? (b + 8'h20) : b;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/qns_step.sv @@
`default_nettype none

// Next-state and result logic for one input byte.
module qns_step #(
	parameter int NAME_LIMIT = qns_pkg::NAME_LIMIT_DEF
) (
	input  wire qns_pkg::scan_state_t cur,
	input  wire logic [7:0]           in_byte,
	output qns_pkg::scan_state_t      nxt,
	output logic                      res_valid,
	output qns_pkg::result_t          res
);

	localparam logic [qns_pkg::LEN_W-1:0] LIMIT   = NAME_LIMIT[qns_pkg::LEN_W-1:0];
	localparam logic [qns_pkg::LEN_W-1:0] LEN_ONE = {{(qns_pkg::LEN_W-1){1'b0}}, 1'b1};

	logic                      do_emit;
	logic [7:0]                emit_ch;
	logic [qns_pkg::LEN_W-1:0] emit_base;
	logic                      do_judge;
	logic [2:0]                judge_code;
	logic                      do_close;
	logic                      do_after;
	logic                      do_drain;
	logic                      is_nul;
	logic [7:0]                pc_inc;

	assign is_nul = in_byte == qns_pkg::CH_NUL;
	assign pc_inc = (cur.part_count != 8'hFF) ? cur.part_count + 8'd1 : cur.part_count;

	always_comb begin
		do_emit    = 1'b0;
		emit_ch    = in_byte;
		emit_base  = cur.part_length;
		do_judge   = 1'b0;
		judge_code = qns_pkg::ST_OK;
		do_close   = 1'b0;
		do_after   = 1'b0;
		do_drain   = 1'b0;
		nxt        = cur;

		// decode what this byte does in the current mode
		case (cur.mode)
			qns_pkg::M_START: begin
				if (qns_pkg::is_blank(in_byte)) begin
					// skip
				end else if (in_byte == qns_pkg::CH_QUOTE) begin
					nxt.part_length = '0;
					nxt.mode        = qns_pkg::M_QUOTE;
				end else if (qns_pkg::starts_name(in_byte)) begin
					nxt.part_length = '0;
					nxt.mode        = qns_pkg::M_PLAIN;
					emit_base       = '0;
					emit_ch         = qns_pkg::to_lower(in_byte);
					do_emit         = 1'b1;
				end else if (in_byte == qns_pkg::CH_DOT) begin
					do_judge   = 1'b1;
					judge_code = qns_pkg::ST_NO_BEFORE;
				end else begin
					do_judge   = 1'b1;
					judge_code = cur.seen_dot ? qns_pkg::ST_NO_AFTER : qns_pkg::ST_INVALID;
				end
			end
			qns_pkg::M_PLAIN: begin
				if (qns_pkg::continues_name(in_byte)) begin
					emit_ch = qns_pkg::to_lower(in_byte);
					do_emit = 1'b1;
				end else begin
					do_close = 1'b1;
				end
			end
			qns_pkg::M_QUOTE: begin
				if (in_byte == qns_pkg::CH_QUOTE) begin
					nxt.mode = qns_pkg::M_QSEEN;
				end else if (is_nul) begin
					do_judge   = 1'b1;
					judge_code = qns_pkg::ST_UNCLOSED;
				end else begin
					do_emit = 1'b1;
				end
			end
			qns_pkg::M_QSEEN: begin
				if (in_byte == qns_pkg::CH_QUOTE) begin
					// doubled quote stands for one quote
					nxt.mode = qns_pkg::M_QUOTE;
					do_emit  = 1'b1;
				end else if (cur.part_length == '0) begin
					do_judge   = 1'b1;
					judge_code = qns_pkg::ST_EMPTY_Q;
				end else begin
					do_close = 1'b1;
				end
			end
			qns_pkg::M_AFTER: begin
				do_after = 1'b1;
			end
			default: begin
				do_drain = 1'b1;
			end
		endcase

		res_valid       = 1'b0;
		res             = '0;
		res.part_number = cur.part_count;

		// character of the current part, dropped past the clip length
		if (do_emit && emit_base < LIMIT) begin
			res_valid       = 1'b1;
			res.has_char    = 1'b1;
			res.name_char   = emit_ch;
			nxt.part_length = emit_base + LEN_ONE;
		end

		// verdict found: finish on the zero byte, else hold it and drain
		if (do_judge) begin
			if (is_nul) begin
				res_valid    = 1'b1;
				res.finished = 1'b1;
				res.status   = judge_code;
				nxt          = qns_pkg::STATE_RESET;
			end else begin
				nxt.verdict = judge_code;
				nxt.mode    = qns_pkg::M_DRAIN;
			end
		end

		// draining: only the zero byte gives a word
		if (do_drain && is_nul) begin
			res_valid    = 1'b1;
			res.finished = 1'b1;
			res.status   = cur.verdict;
			nxt          = qns_pkg::STATE_RESET;
		end

		// part end moves the count on; the word keeps the old part number
		if (do_close) begin
			res_valid       = 1'b1;
			res.part_end    = 1'b1;
			nxt.part_count  = pc_inc;
			nxt.part_length = '0;
		end

		// byte after a part; a plain finish reports the cleared count
		if (do_close || do_after) begin
			if (is_nul) begin
				res_valid    = 1'b1;
				res.finished = 1'b1;
				if (do_after) begin
					res.part_number = 8'd0;
				end
				nxt = qns_pkg::STATE_RESET;
			end else if (qns_pkg::is_blank(in_byte)) begin
				nxt.mode = qns_pkg::M_AFTER;
			end else if (in_byte == qns_pkg::CH_DOT) begin
				nxt.seen_dot = 1'b1;
				nxt.mode     = qns_pkg::M_START;
			end else begin
				nxt.verdict = (in_byte == qns_pkg::CH_PAREN) ?
					qns_pkg::ST_SIGNATURE : qns_pkg::ST_INVALID;
				nxt.mode    = qns_pkg::M_DRAIN;
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/qualified_name_scanner_core.sv @@
`default_nettype none

// Qualified name scanner.
// Input channel: in_valid/in_stall with in_byte, one string byte per word; a
// zero byte ends the string. Output channel: out_valid/out_stall with
// has_char, name_char, part_number, part_end, finished and status.
// A byte that yields a result has it registered in the output register, or in
// the skid register while the output word is held; bytes that yield none
// (whitespace, quotes, clipped characters, bytes after an early verdict)
// produce no word. Throughput is one byte per cycle while in_stall is low:
// the scan state is updated by one combinational step per byte, feeding an
// output register backed by a one-word skid register.
// When the receiver stalls, the output word holds and one more result is
// caught in the skid register; in_stall rises only while that register is
// full, and drops once the output drains.
// Reset (arst_n low, asynchronous) returns the scanner to the start of a
// new string at part zero and empties both output registers.
module qualified_name_scanner_core #(
	parameter int NAME_LIMIT = qns_pkg::NAME_LIMIT_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire  [7:0] in_byte,
	output logic       out_valid,
	input  wire        out_stall,
	output logic       has_char,
	output logic [7:0] name_char,
	output logic [7:0] part_number,
	output logic       part_end,
	output logic       finished,
	output logic [2:0] status
);

	qns_pkg::scan_state_t state_q;
	qns_pkg::scan_state_t state_nxt;
	logic                 res_valid;
	qns_pkg::result_t     res;
	qns_pkg::result_t     out_q;
	qns_pkg::result_t     skid_q;
	logic                 out_valid_q;
	logic                 skid_valid_q;
	logic                 in_acc;
	logic                 out_take;
	logic                 res_acc;

	qns_step #(
		.NAME_LIMIT(NAME_LIMIT)
	) u_step (
		.cur       (state_q),
		.in_byte   (in_byte),
		.nxt       (state_nxt),
		.res_valid (res_valid),
		.res       (res)
	);

	assign in_stall = skid_valid_q;
	assign in_acc   = in_valid && !skid_valid_q;
	assign out_take = out_valid_q && !out_stall;
	assign res_acc  = in_acc && res_valid;

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qns_pkg::STATE_RESET;
		end else if (in_acc) begin
			state_q <= state_nxt;
		end
	end

	// output register and skid word, control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_take) begin
				out_valid_q  <= skid_valid_q || res_acc;
				skid_valid_q <= 1'b0;
			end else if (res_acc) begin
				if (out_valid_q) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end
		end
	end

	// output register and skid word, payload
	always_ff @(posedge clk) begin
		if (out_take) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (res_acc) begin
				out_q <= res;
			end
		end else if (res_acc) begin
			if (out_valid_q) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign has_char    = out_q.has_char;
	assign name_char   = out_q.name_char;
	assign part_number = out_q.part_number;
	assign part_end    = out_q.part_end;
	assign finished    = out_q.finished;
	assign status      = out_q.status;

endmodule

`default_nettype wire
